>>> rtl/lppe_pkg.sv
// shared types, constants and crc helper for the lidar point extractor
`default_nettype none
package lppe_pkg;

  localparam int STORE_DEPTH = 128;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [7:0]  HDR_BYTE         = 8'h54;
  localparam logic [2:0]  VER_TYPE         = 3'd1;
  localparam logic [7:0]  CRC_POLY         = 8'h4D;
  localparam logic [6:0]  PLEN_BASE        = 7'd11;
  localparam logic [6:0]  MAX_PACKET_BYTES = 7'd104;
  localparam logic [12:0] MAX_SCAN_POINTS  = 13'd4096;
  localparam logic [12:0] LIMIT_RESET      = 13'd512;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_burst;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] distance_mm;
    logic [15:0] angle_hundredths;
    logic [7:0]  signal_strength;
    logic [11:0] point_slot;
    logic        bank_id;
    logic [12:0] finished_count;
    logic        last_of_run;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_HUNT_RD, ST_HUNT_CHK, ST_VER, ST_CRC, ST_CRC_CHK,
    ST_ST0, ST_ST1, ST_EN0, ST_EN1, ST_DIV, ST_DADJ,
    ST_PT, ST_D0, ST_D1, ST_D2, ST_PUSH, ST_NEXT, ST_FIN, ST_FLUSH
  } eng_state_t;

  // msb-first crc-8 over one byte
  function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lppe_ram.sv
// generic single write port ram with registered read
`default_nettype none
module lppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

>>> rtl/lppe_front.sv
// input byte queue between the stream and the packet engine
`default_nettype none
module lppe_front import lppe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  in_item_t      item_in,
  input  wire logic     pop,
  output logic          empty,
  output in_item_t      item_out
);
  in_item_t       q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           do_push, do_pop;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign item_out = q_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= item_in;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/lppe_outq.sv
// result queue between the packet engine and the result port
`default_nettype none
module lppe_outq import lppe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  result_t       res_in,
  input  wire logic     pop,
  output logic          empty,
  output result_t       res_out
);
  result_t        q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign res_out = q_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= res_in;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/lppe_engine.sv
// packet engine: hunt, crc check, angle interpolation and bank bookkeeping
`default_nettype none
module lppe_engine import lppe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fe_empty,
  input  in_item_t         fe_item,
  output logic             fe_pop,
  input  wire logic        oq_full,
  output logic             oq_push,
  output result_t          oq_data,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_data
);
  eng_state_t state_r, state_nxt;
  logic [6:0]  base_r, base_nxt, len_r, len_nxt, i_r, i_nxt;
  logic [4:0]  npts_r, npts_nxt;
  logic [6:0]  plen_r, plen_nxt, k_r, k_nxt, pt_off_r, pt_off_nxt;
  logic [7:0]  crc_r, crc_nxt, end_lo_r, end_lo_nxt;
  logic [15:0] start_r, start_nxt, dist_r, dist_nxt;
  logic        neg_r, neg_nxt, eob_r, eob_nxt;
  logic [15:0] dquo_r, dquo_nxt;
  logic [5:0]  drem_r, drem_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  logic [16:0] qd_r, qd_nxt, q_r, q_nxt;
  logic [4:0]  rd_r, rd_nxt, r_r, r_nxt, n_r, n_nxt;
  logic        wbank_r, wbank_nxt;
  logic [12:0] cnt_r [2];
  logic [12:0] cnt_nxt [2];
  logic [12:0] limit_r;
  result_t     new_res_r, new_res_nxt, pend_r, pend_nxt;
  logic        is_scan_r, is_scan_nxt, pend_v_r, pend_v_nxt;

  logic                wr_en;
  logic [STORE_AW-1:0] wr_addr, rd_addr;
  logic [7:0]          wr_data, rdata;
  logic [6:0]          rd_off;

  logic [12:0] lim, cnt_cur;
  logic [4:0]  den;
  logic [6:0]  pl_w;
  logic [15:0] du;
  logic [5:0]  rem_sh, rsum;
  logic        carry;

  lppe_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  assign rd_addr = base_r + rd_off;
  assign lim     = (limit_r > MAX_SCAN_POINTS) ? MAX_SCAN_POINTS : limit_r;
  assign cnt_cur = cnt_r[wbank_r];
  assign den     = npts_r - 5'd1;
  assign pl_w    = PLEN_BASE + {1'b0, rdata[4:0], 1'b0} + {2'b0, rdata[4:0]};
  assign du      = {rdata, end_lo_r} - start_r;
  assign rem_sh  = {drem_r[4:0], dquo_r[15]};
  assign rsum    = {1'b0, r_r} + {1'b0, rd_r};
  assign carry   = (rsum >= {1'b0, den});

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    npts_r    <= npts_nxt;
    plen_r    <= plen_nxt;
    k_r       <= k_nxt;
    pt_off_r  <= pt_off_nxt;
    crc_r     <= crc_nxt;
    end_lo_r  <= end_lo_nxt;
    start_r   <= start_nxt;
    dist_r    <= dist_nxt;
    neg_r     <= neg_nxt;
    eob_r     <= eob_nxt;
    dquo_r    <= dquo_nxt;
    drem_r    <= drem_nxt;
    dcnt_r    <= dcnt_nxt;
    qd_r      <= qd_nxt;
    q_r       <= q_nxt;
    rd_r      <= rd_nxt;
    r_r       <= r_nxt;
    n_r       <= n_nxt;
    new_res_r <= new_res_nxt;
    is_scan_r <= is_scan_nxt;
    pend_r    <= pend_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      base_r   <= '0;
      len_r    <= '0;
      wbank_r  <= 1'b0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      limit_r  <= LIMIT_RESET;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      len_r    <= len_nxt;
      wbank_r  <= wbank_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      if (cfg_we) limit_r <= cfg_data;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    base_nxt    = base_r;
    len_nxt     = len_r;
    i_nxt       = i_r;
    npts_nxt    = npts_r;
    plen_nxt    = plen_r;
    k_nxt       = k_r;
    pt_off_nxt  = pt_off_r;
    crc_nxt     = crc_r;
    end_lo_nxt  = end_lo_r;
    start_nxt   = start_r;
    dist_nxt    = dist_r;
    neg_nxt     = neg_r;
    eob_nxt     = eob_r;
    dquo_nxt    = dquo_r;
    drem_nxt    = drem_r;
    dcnt_nxt    = dcnt_r;
    qd_nxt      = qd_r;
    q_nxt       = q_r;
    rd_nxt      = rd_r;
    r_nxt       = r_r;
    n_nxt       = n_r;
    wbank_nxt   = wbank_r;
    cnt_nxt     = cnt_r;
    new_res_nxt = new_res_r;
    is_scan_nxt = is_scan_r;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    rd_off      = '0;
    wr_en       = 1'b0;
    wr_addr     = base_r + len_r;
    wr_data     = fe_item.data_byte;
    fe_pop      = 1'b0;
    oq_push     = 1'b0;
    oq_data     = pend_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!fe_empty) begin
          fe_pop = 1'b1;
          wr_en  = 1'b1;
          if (len_r >= MAX_PACKET_BYTES) begin
            wr_addr = base_r;
            len_nxt = 7'd1;
          end else begin
            len_nxt = len_r + 7'd1;
          end
          eob_nxt   = fe_item.end_of_burst;
          i_nxt     = '0;
          state_nxt = ST_HUNT_RD;
        end
      end
      ST_HUNT_RD: begin
        rd_off = i_r;
        if (i_r >= len_r) begin
          len_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_HUNT_CHK;
        end
      end
      ST_HUNT_CHK: begin
        if (rdata != HDR_BYTE) begin
          i_nxt     = i_r + 7'd1;
          state_nxt = ST_HUNT_RD;
        end else if (({1'b0, i_r} + 8'd1) >= {1'b0, len_r}) begin
          // lone header at the end: keep it and wait
          base_nxt  = base_r + i_r;
          len_nxt   = len_r - i_r;
          state_nxt = ST_FIN;
        end else begin
          rd_off    = i_r + 7'd1;
          state_nxt = ST_VER;
        end
      end
      ST_VER: begin
        if (rdata[7:5] != VER_TYPE || pl_w > MAX_PACKET_BYTES) begin
          i_nxt     = i_r + 7'd1;
          state_nxt = ST_HUNT_RD;
        end else if (({1'b0, i_r} + {1'b0, pl_w}) > {1'b0, len_r}) begin
          base_nxt  = base_r + i_r;
          len_nxt   = len_r - i_r;
          state_nxt = ST_FIN;
        end else begin
          npts_nxt  = rdata[4:0];
          plen_nxt  = pl_w;
          crc_nxt   = '0;
          k_nxt     = '0;
          rd_off    = i_r;
          state_nxt = ST_CRC;
        end
      end
      ST_CRC: begin
        crc_nxt = crc_byte(crc_r, rdata);
        k_nxt   = k_r + 7'd1;
        if ((k_r + 7'd1) == (plen_r - 7'd1)) begin
          rd_off    = i_r + plen_r - 7'd1;
          state_nxt = ST_CRC_CHK;
        end else begin
          rd_off = i_r + k_r + 7'd1;
        end
      end
      ST_CRC_CHK: begin
        if (rdata != crc_r) begin
          // bad crc: replay from the byte after the header
          i_nxt     = i_r + 7'd1;
          state_nxt = ST_HUNT_RD;
        end else begin
          rd_off    = i_r + 7'd4;
          state_nxt = ST_ST0;
        end
      end
      ST_ST0: begin
        start_nxt[7:0] = rdata;
        rd_off         = i_r + 7'd5;
        state_nxt      = ST_ST1;
      end
      ST_ST1: begin
        start_nxt[15:8] = rdata;
        rd_off          = i_r + plen_r - 7'd5;
        state_nxt       = ST_EN0;
      end
      ST_EN0: begin
        end_lo_nxt = rdata;
        rd_off     = i_r + plen_r - 7'd4;
        state_nxt  = ST_EN1;
      end
      ST_EN1: begin
        neg_nxt    = du[15];
        dquo_nxt   = du[15] ? (~du + 16'd1) : du;
        drem_nxt   = '0;
        dcnt_nxt   = '0;
        qd_nxt     = '0;
        rd_nxt     = '0;
        q_nxt      = '0;
        r_nxt      = '0;
        n_nxt      = '0;
        pt_off_nxt = 7'd6;
        if (npts_r == 5'd0) begin
          i_nxt     = i_r + plen_r;
          state_nxt = ST_HUNT_RD;
        end else if (npts_r == 5'd1) begin
          state_nxt = ST_PT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring divide of |end - start| by n - 1, one bit a cycle
        if (rem_sh >= {1'b0, den}) begin
          drem_nxt = rem_sh - {1'b0, den};
          dquo_nxt = {dquo_r[14:0], 1'b1};
        end else begin
          drem_nxt = rem_sh;
          dquo_nxt = {dquo_r[14:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd15) state_nxt = ST_DADJ;
      end
      ST_DADJ: begin
        // floor quotient and nonnegative remainder of the signed span
        if (neg_r && drem_r[4:0] != 5'd0) begin
          qd_nxt = 17'd0 - ({1'b0, dquo_r} + 17'd1);
          rd_nxt = den - drem_r[4:0];
        end else if (neg_r) begin
          qd_nxt = 17'd0 - {1'b0, dquo_r};
          rd_nxt = '0;
        end else begin
          qd_nxt = {1'b0, dquo_r};
          rd_nxt = drem_r[4:0];
        end
        state_nxt = ST_PT;
      end
      ST_PT: begin
        rd_off    = i_r + pt_off_r;
        state_nxt = ST_D0;
      end
      ST_D0: begin
        dist_nxt[7:0] = rdata;
        rd_off        = i_r + pt_off_r + 7'd1;
        state_nxt     = ST_D1;
      end
      ST_D1: begin
        dist_nxt[15:8] = rdata;
        rd_off         = i_r + pt_off_r + 7'd2;
        state_nxt      = ST_D2;
      end
      ST_D2: begin
        if (dist_r != 16'd0 && rdata != 8'd0 && cnt_cur < lim) begin
          new_res_nxt.result_kind      = KIND_POINT;
          new_res_nxt.distance_mm      = dist_r;
          new_res_nxt.angle_hundredths = start_r + q_r[15:0];
          new_res_nxt.signal_strength  = rdata;
          new_res_nxt.point_slot       = cnt_cur[11:0];
          new_res_nxt.bank_id          = wbank_r;
          new_res_nxt.finished_count   = '0;
          new_res_nxt.last_of_run      = 1'b0;
          cnt_nxt[wbank_r]             = cnt_cur + 13'd1;
          is_scan_nxt                  = 1'b0;
          state_nxt                    = ST_PUSH;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_PUSH: begin
        // the held result goes out once a newer one exists behind it
        if (!pend_v_r || !oq_full) begin
          oq_push    = pend_v_r;
          pend_nxt   = new_res_r;
          pend_v_nxt = 1'b1;
          state_nxt  = is_scan_r ? ST_FLUSH : ST_NEXT;
        end
      end
      ST_NEXT: begin
        n_nxt      = n_r + 5'd1;
        pt_off_nxt = pt_off_r + 7'd3;
        r_nxt      = carry ? 5'(rsum - {1'b0, den}) : rsum[4:0];
        q_nxt      = q_r + qd_r + {16'd0, carry};
        if ((n_r + 5'd1) == npts_r) begin
          i_nxt     = i_r + plen_r;
          state_nxt = ST_HUNT_RD;
        end else begin
          state_nxt = ST_PT;
        end
      end
      ST_FIN: begin
        if (eob_r) begin
          len_nxt = '0;
          if (cnt_cur >= (lim >> 1)) begin
            new_res_nxt.result_kind      = KIND_SCAN;
            new_res_nxt.distance_mm      = '0;
            new_res_nxt.angle_hundredths = '0;
            new_res_nxt.signal_strength  = '0;
            new_res_nxt.point_slot       = '0;
            new_res_nxt.bank_id          = wbank_r;
            new_res_nxt.finished_count   = cnt_cur;
            new_res_nxt.last_of_run      = 1'b0;
            wbank_nxt                    = ~wbank_r;
            cnt_nxt[~wbank_r]            = '0;
            is_scan_nxt                  = 1'b1;
            state_nxt                    = ST_PUSH;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        oq_data.last_of_run = 1'b1;
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (!oq_full) begin
          oq_push    = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/lidar_packet_point_extractor.sv
// top level of the lidar packet point extractor
// Bytes of the lidar serial stream enter through push/full with end_of_burst
// on the last byte of a burst. Packets start with header 0x54, carry type 1
// and up to 31 points, and are checked with CRC-8 (poly 0x4D). Points of a
// good packet with nonzero distance and intensity come out on the result
// queue (empty/pop) with an interpolated angle and a slot in the active
// bank; at a burst end a scan-complete result may swap the banks.
// last_of_run marks the final result caused by one input beat.
// A byte that does not complete a packet is stored and the held bytes hunted;
// the completing byte adds a crc walk over the packet store, the angle fetch
// and step divider, and a fetch and test per point. A crc failure replays the
// held bytes. The engine pops the next byte only once it is back in idle.
// A 4 deep input queue and a 4 deep result queue plus one holding register
// decouple the engine; when the receiver stops popping, the engine waits and
// the input queue fills until full rises. Reset empties both queues, drops
// held bytes, selects bank 0 with both counts zero and sets scan_limit 512.
// The config beat is taken at any time but is meant for an idle block.
`default_nettype none
module lidar_packet_point_extractor import lppe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_burst,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_result_kind,
  output logic [15:0]      out_distance_mm,
  output logic [15:0]      out_angle_hundredths,
  output logic [7:0]       out_signal_strength,
  output logic [11:0]      out_point_slot,
  output logic             out_bank_id,
  output logic [12:0]      out_finished_count,
  output logic             out_last_of_run,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_scan_limit
);
  in_item_t in_item, fe_item;
  logic     fe_empty, fe_pop, oq_full, oq_push;
  result_t  oq_data, res;

  assign in_item.data_byte    = in_data_byte;
  assign in_item.end_of_burst = in_end_of_burst;
  assign cfg_ready            = 1'b1;

  lppe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .item_in  (in_item),
    .pop      (fe_pop),
    .empty    (fe_empty),
    .item_out (fe_item)
  );

  lppe_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .fe_empty (fe_empty),
    .fe_item  (fe_item),
    .fe_pop   (fe_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_data),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_scan_limit)
  );

  lppe_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .full    (oq_full),
    .res_in  (oq_data),
    .pop     (pop),
    .empty   (empty),
    .res_out (res)
  );

  assign out_result_kind      = res.result_kind;
  assign out_distance_mm      = res.distance_mm;
  assign out_angle_hundredths = res.angle_hundredths;
  assign out_signal_strength  = res.signal_strength;
  assign out_point_slot       = res.point_slot;
  assign out_bank_id          = res.bank_id;
  assign out_finished_count   = res.finished_count;
  assign out_last_of_run      = res.last_of_run;
endmodule
`default_nettype wire

>>> tb/sv/lidar_packet_point_extractor_tb.sv
// testbench for the lidar packet point extractor: packet parsing, crc, banks
`timescale 1ns / 100ps
module lidar_packet_point_extractor_tb import lppe_pkg::*; ();

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] in_data_byte = '0;
  logic in_end_of_burst = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic out_result_kind;
  logic [15:0] out_distance_mm;
  logic [15:0] out_angle_hundredths;
  logic [7:0] out_signal_strength;
  logic [11:0] out_point_slot;
  logic out_bank_id;
  logic [12:0] out_finished_count;
  logic out_last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [12:0] cfg_scan_limit = '0;

  lidar_packet_point_extractor dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_data_byte(in_data_byte), .in_end_of_burst(in_end_of_burst),
    .empty(empty), .pop(pop), .out_result_kind(out_result_kind),
    .out_distance_mm(out_distance_mm), .out_angle_hundredths(out_angle_hundredths),
    .out_signal_strength(out_signal_strength), .out_point_slot(out_point_slot),
    .out_bank_id(out_bank_id), .out_finished_count(out_finished_count),
    .out_last_of_run(out_last_of_run), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_scan_limit(cfg_scan_limit)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [7:0] held_bytes [0:103];
  int unsigned held_len;
  logic fill_bank;
  int unsigned bank_fill [0:1];
  int unsigned limit_reg;

  result_t expected_points [$];
  int error_count = 0;
  int idle_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_pop = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [7:0] crc8_over(input int from, input int count);
    logic [7:0] c;
    c = 8'h00;
    for (int k = 0; k < count; k++) begin
      c = c ^ held_bytes[from + k];
      for (int j = 0; j < 8; j++) c = c[7] ? ({c[6:0], 1'b0} ^ 8'h4D) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic int unsigned usable_limit();
    return limit_reg < 4096 ? limit_reg : 4096;
  endfunction

  function automatic void add_points(input int at, input int npts, inout int nres);
    int unsigned first_ang, end_ang, du, pt_dist, inten, cnt;
    int diff, num, den, q, p;
    result_t r;
    first_ang = held_bytes[at + 4] | (held_bytes[at + 5] << 8);
    p = at + 6 + 3 * npts;
    end_ang = held_bytes[p] | (held_bytes[p + 1] << 8);
    du = (end_ang - first_ang) & 16'hFFFF;
    diff = du >= 32768 ? int'(du) - 65536 : int'(du);
    for (int n = 0; n < npts; n++) begin
      p = at + 6 + 3 * n;
      pt_dist = held_bytes[p] | (held_bytes[p + 1] << 8);
      inten = 32'(held_bytes[p + 2]);
      q = 0;
      if (pt_dist == 0 || inten == 0) continue;
      if (npts > 1) begin
        num = diff * n;
        den = npts - 1;
        q = num / den;
        if (num < 0 && (num % den) != 0) q--;
      end
      cnt = bank_fill[fill_bank];
      if (cnt >= usable_limit() || nres >= 63) continue;
      r = '0;
      r.result_kind = KIND_POINT;
      r.distance_mm = pt_dist[15:0];
      r.angle_hundredths = 16'(first_ang + q);
      r.signal_strength = inten[7:0];
      r.point_slot = cnt[11:0];
      r.bank_id = fill_bank;
      expected_points.push_back(r);
      nres++;
      bank_fill[fill_bank] = (cnt + 1) & 13'h1FFF;
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic eob);
    int nres, i, npts, plen, len;
    result_t r;
    nres = 0;
    if (held_len >= 104) held_len = 0;
    held_bytes[held_len] = b;
    held_len++;
    len = held_len;
    i = 0;
    forever begin
      while (i < len && held_bytes[i] != HDR_BYTE) i++;
      if (i + 1 >= len) break;
      if (held_bytes[i + 1][7:5] != VER_TYPE) begin i++; continue; end
      npts = int'(held_bytes[i + 1][4:0]);
      plen = 11 + 3 * npts;
      if (plen > 104) begin i++; continue; end
      if (i + plen > len) break;
      if (crc8_over(i, plen - 1) != held_bytes[i + plen - 1]) begin i++; continue; end
      add_points(i, npts, nres);
      i += plen;
    end
    if (i >= len) held_len = 0;
    else begin
      for (int k = 0; k < len - i; k++) held_bytes[k] = held_bytes[i + k];
      held_len = len - i;
    end
    if (eob) begin
      held_len = 0;
      if (bank_fill[fill_bank] >= usable_limit() / 2) begin
        r = '0;
        r.result_kind = KIND_SCAN;
        r.bank_id = fill_bank;
        r.finished_count = bank_fill[fill_bank][12:0];
        expected_points.push_back(r);
        nres++;
        fill_bank = ~fill_bank;
        bank_fill[fill_bank] = 0;
      end
    end
    if (nres > 0) expected_points[$].last_of_run = 1'b1;
  endfunction

  // sender: waits for acceptance, idling at random with push low; else push stays up between beats
  task automatic send_byte(input logic [7:0] b, input logic eob);
    while (idle_on && $urandom_range(99) < 18) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_end_of_burst <= eob;
    do @(posedge clk); while (full);
    predict_byte(b, eob);
  endtask

  // receiver and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        idle_cycles <= 0;
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result kind", out_result_kind, -1);
        end else begin
          result_t e;
          e = expected_points.pop_front();
          if (out_result_kind !== e.result_kind)
            report_mismatch("result_kind", out_result_kind, e.result_kind);
          if (out_distance_mm !== e.distance_mm)
            report_mismatch("distance_mm", out_distance_mm, e.distance_mm);
          if (out_angle_hundredths !== e.angle_hundredths)
            report_mismatch("angle_hundredths", out_angle_hundredths, e.angle_hundredths);
          if (out_signal_strength !== e.signal_strength)
            report_mismatch("signal_strength", out_signal_strength, e.signal_strength);
          if (out_point_slot !== e.point_slot)
            report_mismatch("point_slot", out_point_slot, e.point_slot);
          if (out_bank_id !== e.bank_id)
            report_mismatch("bank_id", out_bank_id, e.bank_id);
          if (out_finished_count !== e.finished_count)
            report_mismatch("finished_count", out_finished_count, e.finished_count);
          if (out_last_of_run !== e.last_of_run)
            report_mismatch("last_of_run", out_last_of_run, e.last_of_run);
        end
      end else if (push && !full) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      pop <= !hold_pop && !(idle_on && $urandom_range(99) < 18);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [12:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_scan_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = v;
  endtask

  // builds a packet with good or broken crc and sends it
  task automatic send_packet(input int npts, input logic [15:0] st, input logic [15:0] en,
                             input bit bad_crc, input bit eob, input bit zero_some);
    logic [7:0] pkt [0:103];
    int plen;
    logic [7:0] c;
    plen = 11 + 3 * npts;
    pkt[0] = HDR_BYTE;
    pkt[1] = {VER_TYPE, 5'(npts)};
    pkt[2] = 8'($urandom);
    pkt[3] = 8'($urandom);
    pkt[4] = st[7:0];
    pkt[5] = st[15:8];
    for (int n = 0; n < npts; n++) begin
      pkt[6 + 3 * n] = 8'($urandom);
      pkt[7 + 3 * n] = 8'($urandom);
      pkt[8 + 3 * n] = 8'($urandom);
      if (zero_some && $urandom_range(3) == 0) pkt[6 + 3 * n + $urandom_range(2)] = 8'h00;
    end
    pkt[6 + 3 * npts] = en[7:0];
    pkt[7 + 3 * npts] = en[15:8];
    pkt[8 + 3 * npts] = 8'($urandom);
    pkt[9 + 3 * npts] = 8'($urandom);
    c = 8'h00;
    for (int k = 0; k < plen - 1; k++) begin
      c = c ^ pkt[k];
      for (int j = 0; j < 8; j++) c = c[7] ? ({c[6:0], 1'b0} ^ 8'h4D) : {c[6:0], 1'b0};
    end
    pkt[plen - 1] = bad_crc ? ~c : c;
    for (int k = 0; k < plen; k++) send_byte(pkt[k], eob && k == plen - 1);
  endtask

  task automatic test_directed();
    send_packet(0, 16'h0000, 16'hFFFF, 0, 0, 0);
    send_packet(1, 16'hFFFF, 16'h0000, 0, 0, 0);
    send_packet(4, 16'h0000, 16'h8000, 0, 0, 1);
    send_packet(3, 16'hFFF0, 16'h7FFF, 0, 0, 0);
    // wrong type header, header followed by header
    send_byte(HDR_BYTE, 0);
    send_byte(8'hE5, 0);
    send_byte(HDR_BYTE, 0);
    // crc failure hiding a good packet inside the held bytes
    send_byte(HDR_BYTE, 0);
    send_byte(8'h22, 0);
    send_packet(3, 16'h5000, 16'h4000, 0, 0, 0);
    // incomplete packet cut by a burst end
    send_byte(HDR_BYTE, 0);
    send_byte(8'h25, 0);
    send_byte(8'hFF, 1);
    send_packet(2, 16'hABCD, 16'hABCD, 0, 1, 0);
  endtask

  task automatic test_limits();
    write_limit(13'd2);
    send_packet(3, 16'h0010, 16'h0300, 0, 1, 0);
    write_limit(13'd0);
    send_packet(1, 16'h0010, 16'h0300, 0, 1, 0);
    write_limit(13'd1);
    send_byte(8'h00, 1);
    write_limit(13'h1FFF);
    send_byte(8'h00, 1);
    write_limit(13'd4096);
    send_byte(8'h00, 1);
    write_limit(13'd5);
  endtask

  task automatic test_random(input int nbytes);
    int sent, npts, pick;
    sent = 0;
    while (sent < nbytes) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        npts = $urandom_range(99) < 85 ? $urandom_range(6) : $urandom_range(12);
        send_packet(npts, 16'($urandom), 16'($urandom), pick == 6,
                    $urandom_range(5) == 0, 1);
        sent += 11 + 3 * npts;
      end else begin
        send_byte(pick == 7 ? HDR_BYTE : 8'($urandom), $urandom_range(7) == 0);
        sent++;
      end
    end
    send_byte(8'($urandom), 1);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_pop = 1'b1;
        repeat (600) @(posedge clk);
        hold_pop = 1'b0;
      end
      begin
        send_packet(8, 16'h0000, 16'h2000, 0, 0, 0);
        send_packet(2, 16'h2000, 16'h4000, 0, 1, 0);
      end
    join
  endtask

  initial begin
    held_len = 0;
    fill_bank = 1'b0;
    bank_fill[0] = 0;
    bank_fill[1] = 0;
    limit_reg = 512;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_backpressure();
    test_random(10);
    write_limit(13'd40);
    idle_on = 1'b0;
    test_random(20);
    idle_on = 1'b1;
    test_random(10);
    wait_drained();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
